// ===== src/assert_macros.svh =====
// Assertion macros used by the RTL of the sorting block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Concurrent check on the rising clock edge, switched off while reset is low.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Concurrent check that also holds while reset is asserted.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

// ===== src/bsa_pkg.sv =====
// Package with the constants and the sequencer state type of the sorting block.
`timescale 1ns / 1ps

package bsa_pkg;

    // Width of one element.
    localparam int DATA_W = 32;

    // Default capacity of the element store.
    localparam int MAX_ITEMS_DEF = 16;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_LOAD,
        ST_PASS_START,
        ST_PASS_FIRST,
        ST_PASS_STEP,
        ST_PASS_END,
        ST_EMIT
    } bsa_state_t;

endpackage

// ===== src/bubble_sort_ascending_unit.sv =====
// Top level of the ascending bubble sort block: store, sort sequencer and output stage.
`timescale 1ns / 1ps

// The block takes a set of signed 32-bit words, one per input word, with
// tlast closing the set, and returns them in ascending signed order, equal
// values keeping their arrival order. Loading takes one word per cycle.
// The set of n words is then sorted in place in one synchronous memory with
// one read and one write port in n-1 bubble passes; a set of one word skips
// the sort. During emission a read is issued only once the single output
// register is empty, and the word read from the memory is then loaded into
// the output register, so the next word is read only after the last is taken.
// Words beyond MAX_ITEMS are dropped and every result of that set carries
// tuser set. Input is taken only while a set is being loaded; the next set
// may load while the final result still waits at the output.
module bubble_sort_ascending_unit #(
    parameter int MAX_ITEMS = bsa_pkg::MAX_ITEMS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // Input stream.
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [bsa_pkg::DATA_W-1:0] s_axis_tdata,   // [31:0] value
    input  logic                       s_axis_tlast,   // last_in
    // Output stream.
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [bsa_pkg::DATA_W-1:0] m_axis_tdata,   // [31:0] sorted_value
    output logic                       m_axis_tlast,   // last_out
    output logic [0:0]                 m_axis_tuser    // [0] overflow
);

    import bsa_pkg::*;

    `include "assert_macros.svh"

    localparam int IDX_W = $clog2(MAX_ITEMS);
    localparam int CNT_W = $clog2(MAX_ITEMS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ITEMS);

    // Sequencer and datapath registers.
    bsa_state_t               state_reg,    state_next;
    logic [CNT_W-1:0]         count_reg,    count_next;
    logic                     dropped_reg,  dropped_next;
    logic [CNT_W-1:0]         n_reg,        n_next;
    logic                     ovf_reg,      ovf_next;
    logic [IDX_W-1:0]         end_reg,      end_next;
    logic [IDX_W-1:0]         k_reg,        k_next;
    logic signed [DATA_W-1:0] carry_reg,    carry_next;
    logic [CNT_W-1:0]         emit_idx_reg, emit_idx_next;
    logic                     rd_pend_reg,  rd_pend_next;
    logic                     pend_last_reg, pend_last_next;
    logic                     m_valid_reg,  m_valid_next;
    logic [DATA_W-1:0]        m_data_reg,   m_data_next;
    logic                     m_last_reg,   m_last_next;
    logic                     m_user_reg,   m_user_next;

    // Memory port controls.
    logic                     rd_en;
    logic [IDX_W-1:0]         rd_addr;
    logic signed [DATA_W-1:0] rd_data;
    logic                     wr_en;
    logic [IDX_W-1:0]         wr_addr;
    logic [DATA_W-1:0]        wr_data;

    logic [DATA_W-1:0]        mem [MAX_ITEMS];

    logic                     in_acc;
    logic                     full;
    logic [CNT_W-1:0]         held;

    // Element store: one write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

    assign in_acc = s_axis_tvalid && s_axis_tready;
    assign full   = (count_reg == CNT_MAX);
    assign held   = full ? count_reg : (count_reg + CNT_W'(1));

    // Next state, memory accesses and output stage.
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        dropped_next   = dropped_reg;
        n_next         = n_reg;
        ovf_next       = ovf_reg;
        end_next       = end_reg;
        k_next         = k_reg;
        carry_next     = carry_reg;
        emit_idx_next  = emit_idx_reg;
        rd_pend_next   = rd_pend_reg;
        pend_last_next = pend_last_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;
        m_last_next    = m_last_reg;
        m_user_next    = m_user_reg;
        rd_en          = 1'b0;
        rd_addr        = k_reg;
        wr_en          = 1'b0;
        wr_addr        = k_reg;
        wr_data        = carry_reg;
        s_axis_tready  = 1'b0;

        // The output register empties when its word is taken.
        if (m_valid_reg && m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_LOAD:
            begin
                s_axis_tready = 1'b1;
                if (in_acc)
                begin
                    if (!full)
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = count_reg[IDX_W-1:0];
                        wr_data    = s_axis_tdata;
                        count_next = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        dropped_next = 1'b1;
                    end
                    if (s_axis_tlast)
                    begin
                        n_next        = held;
                        ovf_next      = dropped_reg || full;
                        end_next      = IDX_W'(held - CNT_W'(1));
                        count_next    = '0;
                        dropped_next  = 1'b0;
                        emit_idx_next = '0;
                        rd_pend_next  = 1'b0;
                        if (held > CNT_W'(1))
                        begin
                            state_next = ST_PASS_START;
                        end
                        else
                        begin
                            state_next = ST_EMIT;
                        end
                    end
                end
            end

            // Fetch the first element of the pass.
            ST_PASS_START:
            begin
                rd_en      = 1'b1;
                rd_addr    = '0;
                k_next     = '0;
                state_next = ST_PASS_FIRST;
            end

            // The first element becomes the carried value; fetch the second.
            ST_PASS_FIRST:
            begin
                carry_next = rd_data;
                rd_en      = 1'b1;
                rd_addr    = IDX_W'(1);
                state_next = ST_PASS_STEP;
            end

            // Compare the carried value with the next one; the smaller settles at k.
            ST_PASS_STEP:
            begin
                wr_en   = 1'b1;
                wr_addr = k_reg;
                if (carry_reg > rd_data)
                begin
                    wr_data = rd_data;
                end
                else
                begin
                    wr_data    = carry_reg;
                    carry_next = rd_data;
                end
                if ((k_reg + IDX_W'(1)) == end_reg)
                begin
                    state_next = ST_PASS_END;
                end
                else
                begin
                    rd_en   = 1'b1;
                    rd_addr = k_reg + IDX_W'(2);
                    k_next  = k_reg + IDX_W'(1);
                end
            end

            // The largest value of the pass settles at the end position.
            ST_PASS_END:
            begin
                wr_en    = 1'b1;
                wr_addr  = end_reg;
                wr_data  = carry_reg;
                end_next = end_reg - IDX_W'(1);
                if (end_reg == IDX_W'(1))
                begin
                    emit_idx_next = '0;
                    rd_pend_next  = 1'b0;
                    state_next    = ST_EMIT;
                end
                else
                begin
                    state_next = ST_PASS_START;
                end
            end

            // Read each element while the output register is empty.
            ST_EMIT:
            begin
                if (rd_pend_reg)
                begin
                    rd_pend_next = 1'b0;
                    m_valid_next = 1'b1;
                    m_data_next  = rd_data;
                    m_last_next  = pend_last_reg;
                    m_user_next  = ovf_reg;
                    if (pend_last_reg)
                    begin
                        state_next = ST_LOAD;
                    end
                end
                else if (!m_valid_reg)
                begin
                    rd_en          = 1'b1;
                    rd_addr        = emit_idx_reg[IDX_W-1:0];
                    rd_pend_next   = 1'b1;
                    pend_last_next = (emit_idx_reg == (n_reg - CNT_W'(1)));
                    emit_idx_next  = emit_idx_reg + CNT_W'(1);
                end
            end

            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_LOAD;
            count_reg    <= '0;
            dropped_reg  <= 1'b0;
            rd_pend_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            dropped_reg  <= dropped_next;
            rd_pend_reg  <= rd_pend_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        n_reg         <= n_next;
        ovf_reg       <= ovf_next;
        end_reg       <= end_next;
        k_reg         <= k_next;
        carry_reg     <= carry_next;
        emit_idx_reg  <= emit_idx_next;
        pend_last_reg <= pend_last_next;
        m_data_reg    <= m_data_next;
        m_last_reg    <= m_last_next;
        m_user_reg    <= m_user_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tlast  = m_last_reg;
    assign m_axis_tuser  = m_user_reg;

    // A pending read only exists during emission.
    `ASSERT_CLK(a_pend_in_emit, clk, rst_n, rd_pend_reg |-> (state_reg == ST_EMIT), "read pending outside emission")

    // A read is issued only into an empty output register.
    `ASSERT_CLK(a_pend_out_empty, clk, rst_n, rd_pend_reg |-> !m_valid_reg, "read issued while output occupied")

    // A new output word always follows a memory read.
    `ASSERT_CLK(a_out_after_read, clk, rst_n, $rose(m_valid_reg) |-> $past(rd_pend_reg), "output word without a read")

    // The fill count never passes the capacity.
    `ASSERT_CLK(a_count_bound, clk, rst_n, count_reg <= CNT_MAX, "fill count beyond capacity")

    // Sorting stays inside the held elements.
    `ASSERT_CLK(a_sort_bound, clk, rst_n, (state_reg == ST_PASS_STEP) |-> ((k_reg < end_reg) && (CNT_W'(end_reg) < n_reg)), "sort index out of range")

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for the ascending bubble sort block.
`timescale 1ns / 1ps

// Sets of signed words go in on the input stream. A sorting predictor keeps
// its own copy of the store and queues the sorted words that each closing
// word should cause. The output monitor then checks every word that leaves
// the block against the oldest queued word.
module tb_top;

    import bsa_pkg::*;

    localparam int SORT_DEPTH   = MAX_ITEMS_DEF;
    localparam int QUIET_LIMIT  = 3000;
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASE_ITEMS  = 170;
    localparam int N_DIRECTED   = 13;
    localparam int DRAIN_CYCLES = 40;

    // One sorted word as it leaves the block.
    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              last;
        logic              ovf;
    } sorted_word_t;

    // One row of the directed table; rep repeats the word, with tlast only on
    // the final copy. A typed expectation is given only for one-word sets.
    typedef struct {
        logic [DATA_W-1:0] value;
        logic              last;
        int                rep;
        bit                typed;
        sorted_word_t      want;
    } stim_row_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [DATA_W-1:0] s_axis_tdata = '0;
    logic              s_axis_tlast = 1'b0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [DATA_W-1:0] m_axis_tdata;
    logic              m_axis_tlast;
    logic [0:0]        m_axis_tuser;

    // Predictor state: held words, their number and the dropped flag.
    logic [DATA_W-1:0] held_words [SORT_DEPTH];
    int                held_count = 0;
    bit                held_dropped = 1'b0;

    sorted_word_t      expected_words [$];
    sorted_word_t      fresh_words [$];

    int                errors = 0;
    int                items_sent = 0;
    int                snd_idle_pct = 0;
    int                rcv_idle_pct = 0;
    int                hold_req = 0;
    int                hold_left = 0;
    int                quiet_cycles = 0;

    stim_row_t directed_rows [N_DIRECTED] = '{
        '{32'h8000_0000, 1'b1, 1,  1'b1, '{32'h8000_0000, 1'b1, 1'b0}},
        '{32'h7FFF_FFFF, 1'b1, 1,  1'b1, '{32'h7FFF_FFFF, 1'b1, 1'b0}},
        '{32'h0000_0000, 1'b1, 1,  1'b1, '{32'h0000_0000, 1'b1, 1'b0}},
        '{32'hFFFF_FFFF, 1'b1, 1,  1'b1, '{32'hFFFF_FFFF, 1'b1, 1'b0}},
        '{32'h7FFF_FFFF, 1'b0, 1,  1'b0, '{32'h0, 1'b0, 1'b0}},
        '{32'h8000_0000, 1'b1, 1,  1'b0, '{32'h0, 1'b0, 1'b0}},
        '{32'h0000_0001, 1'b0, 1,  1'b0, '{32'h0, 1'b0, 1'b0}},
        '{32'hFFFF_FFFF, 1'b0, 1,  1'b0, '{32'h0, 1'b0, 1'b0}},
        '{32'h0000_0000, 1'b0, 1,  1'b0, '{32'h0, 1'b0, 1'b0}},
        '{32'hFFFF_FFFF, 1'b0, 1,  1'b0, '{32'h0, 1'b0, 1'b0}},
        '{32'h8000_0000, 1'b1, 1,  1'b0, '{32'h0, 1'b0, 1'b0}},
        '{32'hAAAA_5555, 1'b0, 16, 1'b0, '{32'h0, 1'b0, 1'b0}},
        '{32'h5555_AAAA, 1'b1, 1,  1'b0, '{32'h0, 1'b0, 1'b0}}
    };

    bubble_sort_ascending_unit #(
        .MAX_ITEMS (SORT_DEPTH)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Clock with a 10 ns period.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Stores one word and, when it closes the set, sorts the held words and
    // leaves the resulting words in fresh_words.
    function automatic void sort_model_step(input logic [DATA_W-1:0] v, input logic last);
        logic [DATA_W-1:0] t;
        sorted_word_t      w;
        fresh_words.delete();
        if (held_count < SORT_DEPTH)
        begin
            held_words[held_count] = v;
            held_count++;
        end
        else
            held_dropped = 1'b1;
        if (!last)
            return;
        // Adjacent compare-and-swap passes; equal words never swap.
        for (int p = 0; p + 1 < held_count; p++)
            for (int k = 0; k + 1 < held_count - p; k++)
                if ($signed(held_words[k]) > $signed(held_words[k + 1]))
                begin
                    t = held_words[k];
                    held_words[k] = held_words[k + 1];
                    held_words[k + 1] = t;
                end
        for (int k = 0; k < held_count; k++)
        begin
            w.value = held_words[k];
            w.last  = (k + 1 == held_count);
            w.ovf   = held_dropped;
            fresh_words.push_back(w);
        end
        held_count = 0;
        held_dropped = 1'b0;
    endfunction

    // Offers one word from a falling edge, waits for it to be taken and
    // queues what it should cause. Returns at the next falling edge.
    task automatic send_word(input logic [DATA_W-1:0] v, input logic last,
                             input bit typed, input sorted_word_t want);
        if ($urandom_range(99) < snd_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(99) < snd_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= v;
        s_axis_tlast  <= last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sort_model_step(v, last);
        if (typed)
            expected_words.push_back(want);
        else
            foreach (fresh_words[i])
                expected_words.push_back(fresh_words[i]);
        items_sent++;
        @(negedge clk);
    endtask

    // One random set: mostly up to the store's size, now and then longer so
    // that words are dropped. The value mix varies from set to set.
    task automatic send_random_set();
        int                n;
        int                mix;
        logic [DATA_W-1:0] v;
        n = ($urandom_range(7) == 0) ? $urandom_range(SORT_DEPTH + 1, SORT_DEPTH + 4)
                                     : $urandom_range(1, SORT_DEPTH);
        mix = $urandom_range(3);
        for (int i = 0; i < n; i++)
        begin
            case (mix)
                2: v = $urandom_range(8) - 32'd4;
                3:
                begin
                    case ($urandom_range(4))
                        0: v = 32'h8000_0000;
                        1: v = 32'h7FFF_FFFF;
                        2: v = 32'h0000_0000;
                        3: v = 32'hFFFF_FFFF;
                        default: v = $urandom;
                    endcase
                end
                default: v = $urandom;
            endcase
            send_word(v, i == n - 1, 1'b0, '0);
        end
    endtask

    // Receiver: random stalls, or a long hold-off when one is requested.
    always @(negedge clk)
    begin
        if (hold_req > 0)
        begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= rcv_idle_pct);
    end

    // Output monitor: each word taken is checked against the oldest expected one.
    always @(posedge clk)
    begin
        sorted_word_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_words.size() == 0)
            begin
                errors++;
                $error("unexpected sorted word %h", m_axis_tdata);
            end
            else
            begin
                want = expected_words.pop_front();
                if (m_axis_tdata !== want.value)
                begin
                    errors++;
                    $error("sorted_value: expected %h, got %h", want.value, m_axis_tdata);
                end
                if (m_axis_tlast !== want.last)
                begin
                    errors++;
                    $error("last_out: expected %b, got %b", want.last, m_axis_tlast);
                end
                if (m_axis_tuser[0] !== want.ovf)
                begin
                    errors++;
                    $error("overflow: expected %b, got %b", want.ovf, m_axis_tuser[0]);
                end
            end
        end
    end

    // Watchdog on cycles in which neither stream moves a word.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // Main sequence: reset, directed table, then three phases of random sets.
    initial
    begin
        int target;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed table, with the idling of the first phase.
        snd_idle_pct = 19;
        rcv_idle_pct = 75;
        foreach (directed_rows[r])
            for (int i = 0; i < directed_rows[r].rep; i++)
                send_word(directed_rows[r].value,
                          directed_rows[r].last && (i == directed_rows[r].rep - 1),
                          directed_rows[r].typed, directed_rows[r].want);

        target = items_sent;
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    snd_idle_pct = 19;
                    rcv_idle_pct = 75;
                end
                1:
                begin
                    snd_idle_pct = 75;
                    rcv_idle_pct = 19;
                end
                default:
                begin
                    snd_idle_pct = 0;
                    rcv_idle_pct = 0;
                    // Long hold-off on the output while full sets keep coming,
                    // so that the block fills and stalls its input.
                    hold_req = HOLD_CYCLES;
                    for (int s = 0; s < 3; s++)
                        for (int i = 0; i < SORT_DEPTH; i++)
                            send_word($urandom, i == SORT_DEPTH - 1, 1'b0, '0);
                end
            endcase
            target += PHASE_ITEMS;
            while (items_sent < target)
                send_random_set();
        end
        s_axis_tvalid <= 1'b0;

        // Drain, then allow a few more cycles for any stray word.
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
